// ----- hw/rtl/cbpm_pkg.sv -----
package cbpm_pkg;

   localparam int unsigned LEVEL_BITS = 8;
   localparam int unsigned CFG_LEN_BITS = 10;
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 10;
   localparam int unsigned BIT_COUNT_BITS = 4;

   localparam logic [BIT_COUNT_BITS-1:0] BITS_PER_BYTE = 4'd8;

   localparam logic [CFG_LEN_BITS-1:0] SHORT_RESET = 10'd12;
   localparam logic [CFG_LEN_BITS-1:0] LONG_RESET = 10'd24;
   localparam logic [LEVEL_BITS-1:0] HIGH_RESET = 8'hFF;
   localparam logic [LEVEL_BITS-1:0] LOW_RESET = 8'h00;
   localparam logic [LEVEL_BITS-1:0] IDLE_RESET = 8'h7F;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SHORT_PULSE = 3'd0,
      CSR_LONG_PULSE = 3'd1,
      CSR_HIGH_LEVEL = 3'd2,
      CSR_LOW_LEVEL = 3'd3,
      CSR_IDLE_LEVEL = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_LOAD = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      PULSE_SYNC = 2'd0,
      PULSE_FIRST = 2'd1,
      PULSE_SECOND = 2'd2
   } pulse_index_type;

   typedef struct packed {
      op_type op;
      logic [LEVEL_BITS-1:0] data_byte;
   } item_type;

   typedef struct packed {
      logic valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic [CFG_LEN_BITS-1:0] short_pulse_samples;
      logic [CFG_LEN_BITS-1:0] long_pulse_samples;
      logic [LEVEL_BITS-1:0] high_level;
      logic [LEVEL_BITS-1:0] low_level;
      logic [LEVEL_BITS-1:0] idle_level;
   } cfg_type;

endpackage

// ----- hw/rtl/cbpm_req_if.sv -----
interface cbpm_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [7:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink (input valid, input operation, input data_byte, output ready);
endinterface

// ----- hw/rtl/cbpm_rsp_if.sv -----
interface cbpm_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] sample;
   logic sample_valid;
   logic busy_res;
   logic load_rejected;

   modport source (output valid, output sample, output sample_valid, output busy_res,
                   output load_rejected, input ready);
   modport sink (input valid, input sample, input sample_valid, input busy_res,
                 input load_rejected, output ready);
endinterface

// ----- hw/rtl/cbpm_front.sv -----
module cbpm_front
   import cbpm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   cbpm_req_if.sink       req_port,
   input  logic           pop,
   output queue_head_type head
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item;

   assign req_port.ready = (count_ff != 2'd2);
   assign push = req_port.valid && req_port.ready;

   // classify the beat
   always_comb begin
      item.op = (req_port.operation == 1'b1) ? OP_LOAD : OP_TICK;
      item.data_byte = req_port.data_byte;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item = entry_ff[rd_ptr_ff];

endmodule

// ----- hw/rtl/cbpm_back.sv -----
module cbpm_back
   import cbpm_pkg::*;
#(
   parameter int unsigned PULSE_COUNT_BITS = 10
)
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  queue_head_type head,
   output logic           pop,
   cbpm_rsp_if.source     rsp_port
);

   localparam int unsigned PW = PULSE_COUNT_BITS;

   logic [LEVEL_BITS-1:0]     shift_ff, shift_in;
   logic [BIT_COUNT_BITS-1:0] bits_ff, bits_in;
   pulse_index_type           index_ff, index_in;
   logic [PW-1:0]             len_ff, len_in;
   logic [PW-1:0]             pos_ff, pos_in;

   logic                  out_valid_ff, out_valid_in;
   logic [LEVEL_BITS-1:0] out_sample_ff, out_sample_in;
   logic                  out_sv_ff, out_sv_in;
   logic                  out_busy_ff, out_busy_in;
   logic                  out_rej_ff, out_rej_in;

   logic          busy;
   logic          one_bit;
   logic [PW-1:0] half;
   logic [PW-1:0] total;
   logic [PW-1:0] pos_next;
   logic [PW-1:0] short_len;
   logic [PW-1:0] long_len;

   assign pop = head.valid && (!out_valid_ff || rsp_port.ready);
   assign busy = (bits_ff != '0);
   assign one_bit = shift_ff[LEVEL_BITS-1];
   assign half = len_ff >> 1;
   assign total = {len_ff[PW-1:1], 1'b1};
   assign pos_next = pos_ff + {{(PW-1){1'b0}}, 1'b1};
   assign short_len = PW'(cfg.short_pulse_samples);
   assign long_len = PW'(cfg.long_pulse_samples);

   always_comb begin
      shift_in = shift_ff;
      bits_in = bits_ff;
      index_in = index_ff;
      len_in = len_ff;
      pos_in = pos_ff;
      out_sample_in = out_sample_ff;
      out_sv_in = out_sv_ff;
      out_busy_in = out_busy_ff;
      out_rej_in = out_rej_ff;
      out_valid_in = rsp_port.ready ? 1'b0 : out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
         out_sample_in = '0;
         out_sv_in = 1'b0;
         out_rej_in = 1'b0;
         if (head.item.op == OP_LOAD) begin
            out_rej_in = busy;
            if (!busy) begin
               shift_in = head.item.data_byte;
               bits_in = BITS_PER_BYTE;
               index_in = PULSE_SYNC;
               len_in = short_len;
               pos_in = '0;
            end
         end else begin
            out_sv_in = 1'b1;
            if (!busy) begin
               out_sample_in = cfg.idle_level;
            end else begin
               out_sample_in = (pos_ff <= half) ? cfg.high_level : cfg.low_level;
               pos_in = pos_next;
               if (pos_next >= total || pos_next == '0) begin
                  pos_in = '0;
                  if (index_ff == PULSE_SYNC) begin
                     index_in = PULSE_FIRST;
                     len_in = one_bit ? short_len : long_len;
                  end else if (index_ff == PULSE_FIRST && one_bit) begin
                     index_in = PULSE_SECOND;
                     len_in = short_len;
                  end else begin
                     shift_in = {shift_ff[LEVEL_BITS-2:0], 1'b0};
                     bits_in = bits_ff - {{(BIT_COUNT_BITS-1){1'b0}}, 1'b1};
                     index_in = PULSE_SYNC;
                     len_in = (bits_in != '0) ? short_len : '0;
                  end
               end
            end
         end
         out_busy_in = (bits_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         bits_ff <= '0;
         index_ff <= PULSE_SYNC;
         len_ff <= '0;
         pos_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         bits_ff <= bits_in;
         index_ff <= index_in;
         len_ff <= len_in;
         pos_ff <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sample_ff <= out_sample_in;
      out_sv_ff <= out_sv_in;
      out_busy_ff <= out_busy_in;
      out_rej_ff <= out_rej_in;
   end

   assign rsp_port.valid = out_valid_ff;
   assign rsp_port.sample = out_sample_ff;
   assign rsp_port.sample_valid = out_sv_ff;
   assign rsp_port.busy_res = out_busy_ff;
   assign rsp_port.load_rejected = out_rej_ff;

endmodule

// ----- hw/rtl/cassette_bit_pulse_modulator_core.sv -----
// Tape pulse modulator: turns bytes into 8-bit audio samples, MSB first.
// req_port beats carry operation (tick or load) and data_byte; every accepted
// beat yields exactly one rsp_port beat with sample, sample_valid, busy_res and
// load_rejected, in order. A load latches a byte (or is flagged as rejected
// while a byte is in progress); each tick returns one sample of the current
// pulse, or the idle level when nothing is in progress.
// The csr_ port writes the pulse lengths and levels; write only while no beat is in flight.
// Path: a beat taken into the two-entry front queue is executed by the back
// end once it reaches the queue head and the result register is free; its
// result is held in the result register, which drives rsp_port.
// Throughput: one beat per cycle while rsp_port accepts results.
// When rsp_port stalls, the result register holds, the back end stops, and the
// queue fills; req_port.ready drops once both entries are taken.
// Reset (synchronous, active high) empties the queue and output register,
// returns to idle and restores the register defaults.
module cassette_bit_pulse_modulator_core
   import cbpm_pkg::*;
#(
   parameter int unsigned PULSE_COUNT_BITS = 10
)
(
   input  logic                      clock,
   input  logic                      reset,
   cbpm_req_if.sink                  req_port,
   cbpm_rsp_if.source                rsp_port,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   cfg_type        cfg_ff, cfg_in;
   queue_head_type head;
   logic           pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SHORT_PULSE: cfg_in.short_pulse_samples = csr_write_data;
            CSR_LONG_PULSE: cfg_in.long_pulse_samples = csr_write_data;
            CSR_HIGH_LEVEL: cfg_in.high_level = csr_write_data[LEVEL_BITS-1:0];
            CSR_LOW_LEVEL: cfg_in.low_level = csr_write_data[LEVEL_BITS-1:0];
            CSR_IDLE_LEVEL: cfg_in.idle_level = csr_write_data[LEVEL_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_pulse_samples <= SHORT_RESET;
         cfg_ff.long_pulse_samples <= LONG_RESET;
         cfg_ff.high_level <= HIGH_RESET;
         cfg_ff.low_level <= LOW_RESET;
         cfg_ff.idle_level <= IDLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbpm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .pop      (pop),
      .head     (head)
   );

   cbpm_back #(
      .PULSE_COUNT_BITS (PULSE_COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .pop      (pop),
      .rsp_port (rsp_port)
   );

`ifndef SYNTHESIS
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

   a_pop_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_port.valid)
      else $error("executed beat produced no response");

   a_req_fills_queue: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> head.valid)
      else $error("accepted beat missing from queue");
`endif

endmodule
